[rtl/wall_layer_classifier_defines.svh]
// ---------------------------------------------------------------------------
// wall_layer_classifier_defines
// Assertion macros shared by the checker of the wall layer classifier.
// ---------------------------------------------------------------------------
`ifndef WALL_LAYER_CLASSIFIER_DEFINES_SVH
`define WALL_LAYER_CLASSIFIER_DEFINES_SVH

// A condition that must hold at every clock edge outside of reset.
`define WLC_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("%m: assertion failed");

// A condition that must hold in the cycle after a trigger, outside of reset.
`define WLC_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("%m: assertion failed");

// A condition that must hold in the cycle after reset is seen.
`define WLC_ASSERT_AFTER_RESET(label, cond) \
   label: assert property (@(posedge clock) reset |=> (cond)) \
      else $error("%m: assertion failed");

`endif

[rtl/wlc_pkg.sv]
// ---------------------------------------------------------------------------
// wlc_pkg
// Widths, codes and shared types of the wall layer classifier.
// ---------------------------------------------------------------------------
package wlc_pkg;

   localparam int DIST_BITS = 24;
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = FRAC_BITS + 1;
   localparam int SUM_W     = DIST_BITS + 1;
   localparam int LIMIT_W   = POS_W + 1;
   localparam int DIV_STEPS = POS_W;

   localparam logic [POS_W-1:0] FRAC_ONE = POS_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      REGION_LEFT_WALL    = 3'd0,
      REGION_RIGHT_WALL   = 3'd1,
      REGION_LEFT_SEPTUM  = 3'd2,
      REGION_RIGHT_SEPTUM = 3'd3,
      REGION_UNKNOWN      = 3'd4,
      REGION_TWO_SURFACE  = 3'd5
   } region_type;

   typedef enum logic [1:0] {
      LAYER_EPI  = 2'd0,
      LAYER_MID  = 2'd1,
      LAYER_ENDO = 2'd2
   } layer_type;

   typedef enum logic [1:0] {
      CSR_THREE_SURFACES = 2'd0,
      CSR_ENDO_FRACTION  = 2'd1,
      CSR_EPI_FRACTION   = 2'd2
   } csr_index_type;

   // Sideband that travels with an item through the divider.
   typedef struct packed {
      region_type region;
      logic       zero_sum;
   } tag_type;

endpackage

[rtl/wlc_divider.sv]
// ---------------------------------------------------------------------------
// wlc_divider
// Pipelined restoring divider: (inner << FRAC_BITS) / sum, one quotient bit
// per stage, with per-stage valid bits and a ready chain.
// ---------------------------------------------------------------------------
module wlc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [wlc_pkg::DIST_BITS-1:0]  in_inner,
   input  logic [wlc_pkg::SUM_W-1:0]      in_sum,
   input  wlc_pkg::tag_type               in_tag,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [wlc_pkg::POS_W-1:0]      out_quotient,
   output wlc_pkg::tag_type               out_tag
);
   import wlc_pkg::*;

   logic                 valid_ff [DIV_STEPS];
   logic [SUM_W-1:0]     rem_ff   [DIV_STEPS];
   logic [SUM_W-1:0]     div_ff   [DIV_STEPS];
   logic [POS_W-1:0]     quo_ff   [DIV_STEPS];
   tag_type              tag_ff   [DIV_STEPS];
   logic                 ready    [DIV_STEPS+1];

   assign ready[DIV_STEPS] = out_ready;
   assign in_ready         = ready[0];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic             src_valid;
      logic [SUM_W:0]   src_rem;
      logic [SUM_W-1:0] src_div;
      logic [POS_W-1:0] src_quo;
      tag_type          src_tag;
      logic [SUM_W:0]   diff;
      logic             take;
      logic [SUM_W-1:0] rem_in;
      logic [POS_W-1:0] quo_in;

      if (k == 0) begin : g_first
         // The first step tests the top quotient bit against inner itself.
         assign src_valid = in_valid;
         assign src_rem   = {2'b00, in_inner};
         assign src_div   = in_sum;
         assign src_quo   = '0;
         assign src_tag   = in_tag;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = {rem_ff[k-1], 1'b0};
         assign src_div   = div_ff[k-1];
         assign src_quo   = quo_ff[k-1];
         assign src_tag   = tag_ff[k-1];
      end

      assign ready[k] = !valid_ff[k] || ready[k+1];
      assign diff     = src_rem - {1'b0, src_div};
      assign take     = src_rem >= {1'b0, src_div};
      assign rem_in   = take ? diff[SUM_W-1:0] : src_rem[SUM_W-1:0];
      assign quo_in   = {src_quo[POS_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k] && src_valid) begin
            rem_ff[k] <= rem_in;
            div_ff[k] <= src_div;
            quo_ff[k] <= quo_in;
            tag_ff[k] <= src_tag;
         end
      end
   end

   assign out_valid    = valid_ff[DIV_STEPS-1];
   assign out_quotient = quo_ff[DIV_STEPS-1];
   assign out_tag      = tag_ff[DIV_STEPS-1];

endmodule

[rtl/wall_layer_classifier.sv]
// ---------------------------------------------------------------------------
// wall_layer_classifier
// Classifies a mesh node by region and transmural layer from its surface
// distances, with a pipelined divider for the relative wall position.
// ---------------------------------------------------------------------------
// Pipeline: an accepted item passes one select stage, 17 divider stages of one
// quotient bit each and one output stage before its result shows on rsp_valid.
// Throughput: one item per cycle unless the output stalls; each stage advances
// when its successor has room, so bubbles are squeezed out during a stall.
// Reset clears all valid bits and sets three_surfaces to 1 and both
// fractions to 0.
module wall_layer_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [wlc_pkg::DIST_BITS-1:0]  req_dist_outer,
   input  logic [wlc_pkg::DIST_BITS-1:0]  req_dist_left,
   input  logic [wlc_pkg::DIST_BITS-1:0]  req_dist_right,
   input  logic [wlc_pkg::DIST_BITS-1:0]  req_dist_inner,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output wlc_pkg::region_type            rsp_region,
   output logic [wlc_pkg::POS_W-1:0]      rsp_wall_position,
   output wlc_pkg::layer_type             rsp_layer,
   output logic                           rsp_fraction_error,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [wlc_pkg::POS_W-1:0]      csr_data
);
   import wlc_pkg::*;

   // Configuration registers.
   logic             three_ff;
   logic [POS_W-1:0] endo_ff;
   logic [POS_W-1:0] epi_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         three_ff <= 1'b1;
         endo_ff  <= '0;
         epi_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THREE_SURFACES: three_ff <= csr_data[0];
            CSR_ENDO_FRACTION:  endo_ff  <= csr_data;
            CSR_EPI_FRACTION:   epi_ff   <= csr_data;
            default:            ;
         endcase
      end
   end

   // Select stage: region, inner distance and divisor.
   logic                 sel_valid_ff;
   logic [DIST_BITS-1:0] sel_inner_ff;
   logic [SUM_W-1:0]     sel_sum_ff;
   tag_type              sel_tag_ff;
   logic [DIST_BITS-1:0] inner_in;
   logic [SUM_W-1:0]     sum_in;
   tag_type              tag_in;
   logic                 div_in_ready;

   always_comb begin
      if (three_ff) begin
         if (req_dist_right >= req_dist_outer && req_dist_right >= req_dist_left) begin
            tag_in.region = REGION_LEFT_WALL;
            inner_in      = req_dist_left;
         end else if (req_dist_left >= req_dist_outer && req_dist_left >= req_dist_right) begin
            tag_in.region = REGION_RIGHT_WALL;
            inner_in      = req_dist_right;
         end else if ({1'b0, req_dist_left} < {req_dist_right, 1'b0}) begin
            // Outer is the largest: the node lies in the septum.
            tag_in.region = REGION_LEFT_SEPTUM;
            inner_in      = req_dist_left;
         end else begin
            tag_in.region = REGION_RIGHT_SEPTUM;
            inner_in      = req_dist_right;
         end
      end else begin
         tag_in.region = REGION_TWO_SURFACE;
         inner_in      = req_dist_inner;
      end
      sum_in          = {1'b0, inner_in} + {1'b0, req_dist_outer};
      tag_in.zero_sum = (sum_in == '0);
   end

   assign req_ready = !sel_valid_ff || div_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (req_ready) begin
         sel_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         sel_inner_ff <= inner_in;
         sel_sum_ff   <= sum_in;
         sel_tag_ff   <= tag_in;
      end
   end

   // Divider.
   logic             div_out_valid;
   logic             div_out_ready;
   logic [POS_W-1:0] div_quotient;
   tag_type          div_tag;

   wlc_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sel_valid_ff),
      .in_ready     (div_in_ready),
      .in_inner     (sel_inner_ff),
      .in_sum       (sel_sum_ff),
      .in_tag       (sel_tag_ff),
      .out_valid    (div_out_valid),
      .out_ready    (div_out_ready),
      .out_quotient (div_quotient),
      .out_tag      (div_tag)
   );

   // Output stage: layer choice against the fractions.
   logic               rsp_valid_ff;
   region_type         rsp_region_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   layer_type          rsp_layer_ff;
   logic [POS_W-1:0]   pos_in;
   layer_type          layer_in;
   logic [LIMIT_W-1:0] pos_epi;
   logic [LIMIT_W-1:0] frac_sum;

   assign div_out_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pos_in  = div_tag.zero_sum ? '0 : div_quotient;
      // pos < one - epi is the same test as pos + epi < one.
      pos_epi = {1'b0, pos_in} + {1'b0, epi_ff};
      if (pos_in < endo_ff) begin
         layer_in = LAYER_ENDO;
      end else if (pos_epi < {1'b0, FRAC_ONE}) begin
         layer_in = LAYER_MID;
      end else begin
         layer_in = LAYER_EPI;
      end
   end

   assign frac_sum = {1'b0, epi_ff} + {1'b0, endo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_out_ready) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_out_ready && div_out_valid) begin
         rsp_region_ff <= div_tag.region;
         rsp_pos_ff    <= pos_in;
         rsp_layer_ff  <= layer_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_region         = rsp_region_ff;
   assign rsp_wall_position  = rsp_pos_ff;
   assign rsp_layer          = rsp_layer_ff;
   assign rsp_fraction_error = frac_sum > {1'b0, FRAC_ONE};

endmodule

[rtl/wlc_checker.sv]
// ---------------------------------------------------------------------------
// wlc_checker
// Port-level assertions for the wall layer classifier, bound to its top level.
// ---------------------------------------------------------------------------
`include "wall_layer_classifier_defines.svh"

module wlc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_ready,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  wlc_pkg::region_type            rsp_region,
   input  logic [wlc_pkg::POS_W-1:0]      rsp_wall_position,
   input  wlc_pkg::layer_type             rsp_layer
);
   import wlc_pkg::*;

   // After reset no item is in flight and the input side is open.
   `WLC_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid && req_ready)

   // Integer comparison always finds a largest distance.
   `WLC_ASSERT_ALWAYS(a_region_known, !rsp_valid || rsp_region != REGION_UNKNOWN)

   // Inner never exceeds inner plus outer, so the position is at most one.
   `WLC_ASSERT_ALWAYS(a_position_bound, !rsp_valid || rsp_wall_position <= FRAC_ONE)

   // A stalled item stays put with its payload unchanged.
   `WLC_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_region) && $stable(rsp_wall_position) && $stable(rsp_layer))

endmodule

bind wall_layer_classifier wlc_checker u_wlc_checker (.*);
